@@ hdl/mfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types and constants of the meter frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic [7:0] TIMEOUT_RESET = 8'd50;
    localparam logic [7:0] MAX_LEN_RESET = 8'd128;

    localparam logic [7:0] START_MARK = 8'h68;
    localparam logic [7:0] END_MARK   = 8'h16;

    // Frame bytes besides address and data: two start marks, control, length,
    // checksum and end mark.
    localparam int FRAME_OVERHEAD = 6;
    // Checksum and end mark follow the data bytes.
    localparam logic [7:0] TRAILER_BYTES = 8'd2;
    localparam int MAX_FRAME_BYTES = 255;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_READ    = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_HUNT   = 7'b0000010,
        PH_ADDR   = 7'b0000100,
        PH_SECOND = 7'b0001000,
        PH_CTRL   = 7'b0010000,
        PH_LEN    = 7'b0100000,
        PH_DATA   = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_item;

endpackage

@@ hdl/mfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mfr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_front
// Accepts input items, classifies the command and queues them for the parser.
// ----------------------------------------------------------------------------
module mfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_cmd,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_read_index,
    output mfr_pkg::t_item o_item,
    output logic          o_item_valid,
    input  logic          i_item_pop
);

    mfr_pkg::t_item r_slot [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;
    mfr_pkg::t_item w_item;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_item.rx_byte    = i_rx_byte;
        w_item.read_index = i_read_index;
        unique case (i_cmd)
            mfr_pkg::CMD_START: w_item.kind = mfr_pkg::KIND_START;
            mfr_pkg::CMD_BYTE:  w_item.kind = mfr_pkg::KIND_BYTE;
            mfr_pkg::CMD_TICK:  w_item.kind = mfr_pkg::KIND_TICK;
            default:            w_item.kind = mfr_pkg::KIND_READ;
        endcase
    end

    assign o_ready      = (r_count != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_item_pop && (r_count != 2'd0);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_item;
        end
    end

endmodule

@@ hdl/mfr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_back
// Frame parser, frame buffer and result pipeline of the meter frame receiver.
// ----------------------------------------------------------------------------
module mfr_back #(
    parameter int BUFFER_DEPTH  = 256,
    parameter int ADDRESS_BYTES = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mfr_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_pop,
    input  logic [7:0]     i_timeout_ticks,
    input  logic [7:0]     i_max_data_length,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [7:0]     o_frame_length,
    output logic [7:0]     o_read_byte
);

    localparam int STORE_DEPTH = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
    localparam int AW          = $clog2(STORE_DEPTH);

    mfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_byte_count, n_byte_count;
    logic [7:0]      r_expected, n_expected;
    logic [7:0]      r_rx_len, n_rx_len;
    logic [7:0]      r_pos, n_pos;
    logic [7:0]      r_ticks, n_ticks;

    // Result stage ahead of the output register; read data arrives here.
    logic            r_s1_valid;
    mfr_pkg::t_status r_s1_status;
    logic [7:0]      r_s1_len;
    logic            r_s1_hit;

    logic            r_out_valid;
    mfr_pkg::t_status r_out_status;
    logic [7:0]      r_out_len;
    logic [7:0]      r_out_data;

    logic            w_s1_move;
    logic            w_exec;
    logic            w_res;
    mfr_pkg::t_status w_res_status;
    logic [7:0]      w_res_len;
    logic            w_we;
    logic            w_re;
    logic [7:0]      w_rdata;
    logic [7:0]      w_ticks_inc;
    logic            w_too_long;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_ready);
    assign w_exec     = i_item_valid && (!r_s1_valid || w_s1_move);
    assign o_item_pop = w_exec;

    assign w_ticks_inc = r_ticks + 8'd1;
    assign w_too_long  = (i_item.rx_byte > i_max_data_length)
        || ((int'(i_item.rx_byte) + ADDRESS_BYTES + mfr_pkg::FRAME_OVERHEAD)
            > mfr_pkg::MAX_FRAME_BYTES)
        || ((int'(i_item.rx_byte) + ADDRESS_BYTES + mfr_pkg::FRAME_OVERHEAD)
            > BUFFER_DEPTH);

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_expected   = r_expected;
        n_rx_len     = r_rx_len;
        n_pos        = r_pos;
        n_ticks      = r_ticks;
        w_res        = 1'b0;
        w_res_status = mfr_pkg::ST_DONE;
        w_res_len    = 8'd0;
        w_we         = 1'b0;
        w_re         = 1'b0;
        if (w_exec) begin
            unique case (i_item.kind)
                mfr_pkg::KIND_START: begin
                    n_byte_count = 8'd0;
                    n_expected   = 8'd0;
                    n_rx_len     = 8'd0;
                    n_ticks      = 8'd0;
                    n_pos        = 8'd0;
                    n_phase      = mfr_pkg::PH_HUNT;
                    if (i_timeout_ticks == 8'd0) begin
                        n_phase      = mfr_pkg::PH_IDLE;
                        w_res        = 1'b1;
                        w_res_status = mfr_pkg::ST_TIMEOUT;
                    end
                end
                mfr_pkg::KIND_BYTE: begin
                    if (r_phase != mfr_pkg::PH_IDLE) begin
                        w_we = (int'(r_pos) < BUFFER_DEPTH);
                    end
                    unique case (r_phase)
                        mfr_pkg::PH_HUNT: begin
                            if (i_item.rx_byte == mfr_pkg::START_MARK) begin
                                n_pos        = 8'd1;
                                n_rx_len     = 8'd1;
                                n_expected   = 8'(ADDRESS_BYTES);
                                n_byte_count = 8'd0;
                                n_phase      = mfr_pkg::PH_ADDR;
                            end
                        end
                        mfr_pkg::PH_ADDR: begin
                            n_pos        = r_pos + 8'd1;
                            n_rx_len     = r_rx_len + 8'd1;
                            n_byte_count = r_byte_count + 8'd1;
                            if (n_byte_count >= r_expected) begin
                                n_phase = mfr_pkg::PH_SECOND;
                            end
                        end
                        mfr_pkg::PH_SECOND: begin
                            if (i_item.rx_byte != mfr_pkg::START_MARK) begin
                                n_phase = mfr_pkg::PH_HUNT;
                                n_pos   = 8'd0;
                            end else begin
                                n_pos    = r_pos + 8'd1;
                                n_rx_len = r_rx_len + 8'd1;
                                n_phase  = mfr_pkg::PH_CTRL;
                            end
                        end
                        mfr_pkg::PH_CTRL: begin
                            n_pos    = r_pos + 8'd1;
                            n_rx_len = r_rx_len + 8'd1;
                            n_phase  = mfr_pkg::PH_LEN;
                        end
                        mfr_pkg::PH_LEN: begin
                            n_rx_len     = r_rx_len + 8'd1;
                            n_byte_count = 8'd0;
                            if (w_too_long) begin
                                n_phase = mfr_pkg::PH_HUNT;
                                n_pos   = 8'd0;
                            end else begin
                                n_pos      = r_pos + 8'd1;
                                n_expected = i_item.rx_byte + mfr_pkg::TRAILER_BYTES;
                                n_phase    = mfr_pkg::PH_DATA;
                            end
                        end
                        mfr_pkg::PH_DATA: begin
                            n_rx_len     = r_rx_len + 8'd1;
                            n_byte_count = r_byte_count + 8'd1;
                            if (n_byte_count >= r_expected) begin
                                if (i_item.rx_byte == mfr_pkg::END_MARK) begin
                                    n_phase      = mfr_pkg::PH_IDLE;
                                    w_res        = 1'b1;
                                    w_res_status = mfr_pkg::ST_DONE;
                                    w_res_len    = n_rx_len;
                                end else begin
                                    n_phase = mfr_pkg::PH_HUNT;
                                    n_pos   = 8'd0;
                                end
                            end else begin
                                n_pos = r_pos + 8'd1;
                            end
                        end
                        default: begin
                            // Idle: bytes are ignored.
                        end
                    endcase
                end
                mfr_pkg::KIND_TICK: begin
                    if (r_phase != mfr_pkg::PH_IDLE) begin
                        n_ticks = w_ticks_inc;
                        if (w_ticks_inc >= i_timeout_ticks) begin
                            n_phase      = mfr_pkg::PH_IDLE;
                            w_res        = 1'b1;
                            w_res_status = mfr_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default: begin
                    w_res        = 1'b1;
                    w_res_status = mfr_pkg::ST_READ;
                    w_re         = (int'(i_item.read_index) < BUFFER_DEPTH);
                end
            endcase
        end
    end

    mfr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_pos[AW-1:0]),
        .i_wdata(i_item.rx_byte),
        .i_re   (w_re),
        .i_raddr(i_item.read_index[AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mfr_pkg::PH_IDLE;
            r_byte_count <= 8'd0;
            r_expected   <= 8'd0;
            r_rx_len     <= 8'd0;
            r_pos        <= 8'd0;
            r_ticks      <= 8'd0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_expected   <= n_expected;
            r_rx_len     <= n_rx_len;
            r_pos        <= n_pos;
            r_ticks      <= n_ticks;
            if (w_exec) begin
                r_s1_valid <= w_res;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_s1_status <= w_res_status;
            r_s1_len    <= w_res_len;
            r_s1_hit    <= w_re;
        end
        if (w_s1_move) begin
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
            r_out_data   <= r_s1_hit ? w_rdata : 8'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_frame_length = r_out_len;
    assign o_read_byte    = r_out_data;

endmodule

@@ hdl/meter_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_receiver
// Serial meter frame receiver with frame buffer and tick timeout.
// ----------------------------------------------------------------------------
// Each input item carries a command in s_axis_tuser (start, received byte,
// tick, read stored byte) and the byte and read index in s_axis_tdata.
// Start clears the parser and the tick count; bytes outside idle are stored and parsed
// as a 0x68-framed meter frame; ticks count toward the timeout register.
// A result item leaves on m_axis with the status in m_axis_tuser and the
// frame length and read byte in m_axis_tdata. Byte and tick items cause a
// result only on frame completion or timeout; read items always answer.
// Throughput is one item per cycle while m_axis_tready is high. A result
// passes from the input queue through the parser step and the frame buffer
// read into the result stage, then into the output register.
// When m_axis_tready is low, results wait in the output register and the
// stage before it, then the two-entry input queue fills and s_axis_tready
// drops. Reset empties the queue and pipeline, idles the parser and loads
// the register defaults (timeout 50 ticks, length limit 128). The frame
// buffer is not cleared. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module meter_frame_receiver #(
    parameter int BUFFER_DEPTH  = 256,
    parameter int ADDRESS_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] frame_length, [15:8] read_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]     r_timeout_ticks;
    logic [7:0]     r_max_data_length;
    mfr_pkg::t_item w_item;
    logic           w_item_valid;
    logic           w_item_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks   <= mfr_pkg::TIMEOUT_RESET;
            r_max_data_length <= mfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfr_pkg::CFG_TIMEOUT: r_timeout_ticks   <= i_cfg_data;
                default:              r_max_data_length <= i_cfg_data;
            endcase
        end
    end

    mfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_rx_byte   (s_axis_tdata[7:0]),
        .i_read_index(s_axis_tdata[15:8]),
        .o_item      (w_item),
        .o_item_valid(w_item_valid),
        .i_item_pop  (w_item_pop)
    );

    mfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDRESS_BYTES(ADDRESS_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (w_item),
        .i_item_valid     (w_item_valid),
        .o_item_pop       (w_item_pop),
        .i_timeout_ticks  (r_timeout_ticks),
        .i_max_data_length(r_max_data_length),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_status         (m_axis_tuser),
        .o_frame_length   (m_axis_tdata[7:0]),
        .o_read_byte      (m_axis_tdata[15:8])
    );

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == mfr_pkg::ST_DONE)
            || (m_axis_tuser == mfr_pkg::ST_TIMEOUT)
            || (m_axis_tuser == mfr_pkg::ST_READ))
        else $error("undefined result status");

    a_read_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == mfr_pkg::ST_READ))
            |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("read result carries a frame length");

    a_timeout_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == mfr_pkg::ST_TIMEOUT))
            |-> (m_axis_tdata == 16'd0))
        else $error("timeout result carries data");

endmodule

@@ tb/tb_meter_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_meter_frame_receiver
// Self-checking testbench for the meter frame receiver. Commands stream in on
// s_axis with random gaps. A cycle-free predictor of the parser, tick timeout
// and frame buffer computes the expected results, and each result on m_axis
// is checked against them in order. The run walks through several settings of
// the timeout and length limit registers and includes a long output stall.
// ----------------------------------------------------------------------------
module tb_meter_frame_receiver;

    localparam int STORE_DEPTH   = 256;
    localparam int ADDR_BYTES    = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        mfr_pkg::t_status status;
        logic [7:0]       frame_length;
        logic [7:0]       read_byte;
    } t_outcome;

    // Predicts the receiver item by item and holds the results still owed.
    class frame_tracker;
        logic [7:0]      timeout_ticks;
        logic [7:0]      max_len;
        mfr_pkg::t_phase phase;
        logic [7:0]      byte_count;
        logic [7:0]      expected_count;
        logic [7:0]      received_length;
        logic [7:0]      write_pos;
        logic [7:0]      ticks_elapsed;
        logic [7:0]      store [STORE_DEPTH];
        bit              written [STORE_DEPTH];
        int              written_list [$];
        t_outcome        pending_results [$];
        int              mismatches;
        int              frames_done;
        int              timeouts;
        int              reads;

        function new();
            timeout_ticks   = mfr_pkg::TIMEOUT_RESET;
            max_len         = mfr_pkg::MAX_LEN_RESET;
            phase           = mfr_pkg::PH_IDLE;
            byte_count      = '0;
            expected_count  = '0;
            received_length = '0;
            write_pos       = '0;
            ticks_elapsed   = '0;
            mismatches      = 0;
            frames_done     = 0;
            timeouts        = 0;
            reads           = 0;
        endfunction

        function void set_register(logic index, logic [7:0] value);
            if (index == mfr_pkg::CFG_TIMEOUT) begin
                timeout_ticks = value;
            end else begin
                max_len = value;
            end
        endfunction

        function void owe(mfr_pkg::t_status st, logic [7:0] len, logic [7:0] rd);
            t_outcome o;
            o.status       = st;
            o.frame_length = len;
            o.read_byte    = rd;
            pending_results.push_back(o);
        endfunction

        function void restart_hunt();
            phase     = mfr_pkg::PH_HUNT;
            write_pos = '0;
        endfunction

        // Stores the byte and advances the parser; true when a frame completes.
        function bit absorb_byte(logic [7:0] b);
            int total;
            store[write_pos] = b;
            if (!written[write_pos]) begin
                written[write_pos] = 1'b1;
                written_list.push_back(int'(write_pos));
            end
            case (phase)
                mfr_pkg::PH_HUNT: begin
                    if (b == mfr_pkg::START_MARK) begin
                        write_pos       = 8'd1;
                        received_length = 8'd1;
                        expected_count  = 8'(ADDR_BYTES);
                        byte_count      = '0;
                        phase           = mfr_pkg::PH_ADDR;
                    end
                end
                mfr_pkg::PH_ADDR: begin
                    write_pos       += 8'd1;
                    received_length += 8'd1;
                    byte_count      += 8'd1;
                    if (byte_count >= expected_count) phase = mfr_pkg::PH_SECOND;
                end
                mfr_pkg::PH_SECOND: begin
                    if (b != mfr_pkg::START_MARK) begin
                        restart_hunt();
                    end else begin
                        write_pos       += 8'd1;
                        received_length += 8'd1;
                        phase            = mfr_pkg::PH_CTRL;
                    end
                end
                mfr_pkg::PH_CTRL: begin
                    write_pos       += 8'd1;
                    received_length += 8'd1;
                    phase            = mfr_pkg::PH_LEN;
                end
                mfr_pkg::PH_LEN: begin
                    received_length += 8'd1;
                    byte_count       = '0;
                    total = int'(b) + ADDR_BYTES + mfr_pkg::FRAME_OVERHEAD;
                    if (b > max_len || total > mfr_pkg::MAX_FRAME_BYTES
                            || total > STORE_DEPTH) begin
                        restart_hunt();
                    end else begin
                        write_pos     += 8'd1;
                        expected_count = b + mfr_pkg::TRAILER_BYTES;
                        phase          = mfr_pkg::PH_DATA;
                    end
                end
                mfr_pkg::PH_DATA: begin
                    received_length += 8'd1;
                    byte_count      += 8'd1;
                    if (byte_count >= expected_count) begin
                        if (b == mfr_pkg::END_MARK) begin
                            phase = mfr_pkg::PH_IDLE;
                            return 1'b1;
                        end
                        restart_hunt();
                    end else begin
                        write_pos += 8'd1;
                    end
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        // Notes an accepted item; returns false when the block ignores it.
        function bit take_item(mfr_pkg::t_kind kind, logic [7:0] rx, logic [7:0] idx);
            case (kind)
                mfr_pkg::KIND_START: begin
                    byte_count      = '0;
                    expected_count  = '0;
                    received_length = '0;
                    ticks_elapsed   = '0;
                    restart_hunt();
                    if (timeout_ticks == 8'd0) begin
                        phase = mfr_pkg::PH_IDLE;
                        timeouts++;
                        owe(mfr_pkg::ST_TIMEOUT, 8'd0, 8'd0);
                    end
                    return 1'b1;
                end
                mfr_pkg::KIND_BYTE: begin
                    if (phase == mfr_pkg::PH_IDLE) return 1'b0;
                    if (absorb_byte(rx)) begin
                        frames_done++;
                        owe(mfr_pkg::ST_DONE, received_length, 8'd0);
                    end
                    return 1'b1;
                end
                mfr_pkg::KIND_TICK: begin
                    if (phase == mfr_pkg::PH_IDLE) return 1'b0;
                    ticks_elapsed += 8'd1;
                    if (ticks_elapsed >= timeout_ticks) begin
                        phase = mfr_pkg::PH_IDLE;
                        timeouts++;
                        owe(mfr_pkg::ST_TIMEOUT, 8'd0, 8'd0);
                    end
                    return 1'b1;
                end
                default: begin
                    reads++;
                    owe(mfr_pkg::ST_READ, 8'd0, store[idx]);
                    return 1'b1;
                end
            endcase
        endfunction

        function void match_result(logic [1:0] status, logic [15:0] data);
            t_outcome want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing owed: status %0d length %0d %s %02h",
                             $realtime, status, data[7:0], "byte", data[15:8]);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || data[7:0] !== want.frame_length ||
                    data[15:8] !== want.read_byte) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: expected status %0d length %0d byte %02h, ",
                              "got status %0d length %0d byte %02h"},
                             $realtime, want.status, want.frame_length, want.read_byte,
                             status, data[7:0], data[15:8]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [7:0] rx_byte, [15:8] read_index
    logic [1:0]  s_axis_tuser;    // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] frame_length, [15:8] read_byte
    logic [1:0]  m_axis_tuser;    // [1:0] status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    frame_tracker tracker;
    bit           steady;
    bit           hold_request;
    int           items_taken;
    int           settings_written;

    meter_frame_receiver #(
        .BUFFER_DEPTH  (STORE_DEPTH),
        .ADDRESS_BYTES (ADDR_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Called right after a falling edge; returns at the falling edge after the
    // item was taken, with valid still high.
    task automatic send_item(mfr_pkg::t_kind kind, logic [7:0] rx, logic [7:0] idx);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {idx, rx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        void'(tracker.take_item(kind, rx, idx));
        items_taken++;
        @(negedge i_clk);
    endtask

    // Reads only positions that some byte has already been stored at.
    task automatic read_stored();
        int n;
        n = tracker.written_list.size();
        if (n == 0) return;
        send_item(mfr_pkg::KIND_READ, any_byte(),
                  8'(tracker.written_list[$urandom_range(0, n - 1)]));
    endtask

    task automatic feed_byte(logic [7:0] b);
        if ($urandom_range(0, 99) < 4) send_item(mfr_pkg::KIND_TICK, any_byte(), any_byte());
        if ($urandom_range(0, 99) < 5) read_stored();
        send_item(mfr_pkg::KIND_BYTE, b, any_byte());
    endtask

    task automatic send_frame();
        int         len;
        int         limit;
        int         pick;
        logic [7:0] b;
        limit = int'(tracker.max_len);
        if (tracker.phase == mfr_pkg::PH_IDLE || $urandom_range(0, 99) < 10)
            send_item(mfr_pkg::KIND_START, any_byte(), any_byte());
        repeat ($urandom_range(0, 2)) begin
            b = any_byte();
            if (b == mfr_pkg::START_MARK) b = ~b;
            feed_byte(b);
        end
        feed_byte(mfr_pkg::START_MARK);
        repeat (ADDR_BYTES) feed_byte(any_byte());
        if ($urandom_range(0, 99) < 6) begin
            b = any_byte();
            if (b == mfr_pkg::START_MARK) b = ~b;
            feed_byte(b);
            return;
        end
        feed_byte(mfr_pkg::START_MARK);
        feed_byte(any_byte());
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
            len = $urandom_range(0, limit < 16 ? limit : 16);
        end else if (pick < 90) begin
            len = limit;
        end else if (pick < 95) begin
            len = limit + 1;
        end else begin
            len = $urandom_range(0, 255);
        end
        feed_byte(8'(len));
        if (len > limit) return;
        // Data bytes and the checksum, which the block does not verify.
        repeat (len + 1) feed_byte(any_byte());
        if ($urandom_range(0, 99) < 90) begin
            b = mfr_pkg::END_MARK;
        end else begin
            b = any_byte();
            if (b == mfr_pkg::END_MARK) b = ~b;
        end
        feed_byte(b);
    endtask

    task automatic run_phase(int count);
        int target;
        int pick;
        target = items_taken + count;
        while (items_taken < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_frame();
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6)) read_stored();
            end else begin
                send_item(mfr_pkg::t_kind'($urandom_range(mfr_pkg::KIND_START,
                                                          mfr_pkg::KIND_TICK)),
                          any_byte(), any_byte());
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after its last write.
    task automatic write_reg(logic index, logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_register(index, value);
        @(negedge i_clk);
    endtask

    task automatic write_settings(logic [7:0] timeout, logic [7:0] max_length);
        write_reg(mfr_pkg::CFG_TIMEOUT, timeout);
        write_reg(mfr_pkg::CFG_MAX_LEN, max_length);
        i_cfg_valid <= 1'b0;
        settings_written++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_result(m_axis_tuser, m_axis_tdata);
    end

    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                m_axis_tready <= steady || $urandom_range(0, 99) >= 32;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        tracker          = new();
        steady           = 1'b0;
        hold_request     = 1'b0;
        items_taken      = 0;
        settings_written = 0;
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = mfr_pkg::KIND_START;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = mfr_pkg::CFG_TIMEOUT;
        i_cfg_data       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset settings. Byte and tick before any start
        // are ignored.
        send_item(mfr_pkg::KIND_BYTE, mfr_pkg::START_MARK, 8'hFF);
        send_item(mfr_pkg::KIND_TICK, 8'hFF, 8'h00);
        send_item(mfr_pkg::KIND_START, 8'h00, 8'hFF);
        send_item(mfr_pkg::KIND_BYTE, 8'h00, 8'h00);
        send_item(mfr_pkg::KIND_BYTE, mfr_pkg::START_MARK, 8'hFF);
        send_item(mfr_pkg::KIND_BYTE, 8'hFF, 8'h00);
        send_item(mfr_pkg::KIND_BYTE, 8'h00, 8'hFF);
        send_item(mfr_pkg::KIND_BYTE, 8'hAA, 8'h55);
        send_item(mfr_pkg::KIND_BYTE, 8'h55, 8'hAA);
        send_item(mfr_pkg::KIND_BYTE, mfr_pkg::START_MARK, 8'h00);
        send_item(mfr_pkg::KIND_BYTE, mfr_pkg::END_MARK, 8'hFF);
        // Wrong second start mark, then a restart while receiving.
        send_item(mfr_pkg::KIND_BYTE, 8'h55, 8'h00);
        send_item(mfr_pkg::KIND_START, 8'hFF, 8'h00);
        send_item(mfr_pkg::KIND_BYTE, mfr_pkg::START_MARK, 8'h00);
        repeat (ADDR_BYTES) send_item(mfr_pkg::KIND_BYTE, any_byte(), any_byte());
        send_item(mfr_pkg::KIND_BYTE, mfr_pkg::START_MARK, 8'hFF);
        send_item(mfr_pkg::KIND_BYTE, 8'hFF, 8'h00);
        // Length byte far above the limit sends the parser back to hunting.
        send_item(mfr_pkg::KIND_BYTE, 8'hFF, 8'hFF);
        send_item(mfr_pkg::KIND_TICK, 8'h00, 8'h00);
        send_item(mfr_pkg::KIND_TICK, 8'hFF, 8'hFF);

        // Timeout lowered below the ticks already counted fires on the next tick.
        drain_results();
        write_reg(mfr_pkg::CFG_TIMEOUT, 8'd1);
        i_cfg_valid <= 1'b0;
        send_item(mfr_pkg::KIND_TICK, any_byte(), any_byte());

        drain_results();
        write_settings(8'd255, 8'd200);
        steady = 1'b1;
        run_phase(120);
        steady = 1'b0;
        run_phase(130);

        // Zero timeout: every start answers with a timeout at once.
        drain_results();
        write_settings(8'd0, 8'd0);
        run_phase(15);

        drain_results();
        write_settings(8'd3, 8'd10);
        run_phase(150);

        drain_results();
        write_settings(8'd255, 8'd0);
        run_phase(150);

        drain_results();
        write_settings(8'd120, 8'd64);
        run_phase(20);
        // The output stalls while reads keep arriving until the input backs up.
        hold_request = 1'b1;
        repeat (40) read_stored();
        run_phase(180);

        drain_results();
        write_settings(8'd1, 8'd200);
        run_phase(120);

        drain_results();
        $display("Sent %0d items over %0d register settings, with one %0d-cycle output stall.",
                 items_taken, settings_written, HOLD_CYCLES);
        $display("Checked %0d completed frames, %0d timeouts, %0d stored-byte reads.",
                 tracker.frames_done, tracker.timeouts, tracker.reads);
        $display("Mismatches: %0d.", tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
